// ----- hdl/almm_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the multimap engine.
package almm_pkg;

	// Store geometry; null link is encoded as CAPACITY
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_MIN    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Which datapath register feeds the result fields
	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_PEND = 2'd1,
		SRC_BEST = 2'd2
	} src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    rd_free;
		logic    rd_head;
		logic    walk_adv;
		logic    add_wr;
		logic    unlink_a;
		logic    unlink_b;
		logic    emit;
		src_t    emit_src;
		status_t emit_status;
		logic    emit_last;
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic list_nil;
		logic cnt_zero;
		logic key_hit;
		logic pair_hit;
		logic walk_end;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hdl/almm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module almm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/almm_dp.sv -----
// Datapath: key/value/link stores, list and free-chain heads, walk registers, result register.
module almm_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  almm_pkg::dp_ctrl_t       ctl,
	output almm_pkg::dp_stat_t       stat,
	input  logic [1:0]               in_cmd,
	input  logic [31:0]              in_key,
	input  logic [31:0]              in_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               out_status,
	output logic [31:0]              out_found,
	output logic [31:0]              out_smallest,
	output logic                     out_last,
	output logic [6:0]               out_count,
	output logic                     out_empty
);
	import almm_pkg::*;

	cmd_t               cmd_q;
	logic [DATA_W-1:0]  key_q, val_q;
	logic [LINK_W-1:0]  list_head_q, free_head_q, cur_q, prev_q;
	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  steps_q;
	logic [DATA_W-1:0]  best_q, pend_q;
	logic               pend_valid_q;
	logic [CAPACITY-1:0] link_ok_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic               out_valid_q;

	logic               re;
	logic [ADDR_W-1:0]  raddr;
	logic [DATA_W-1:0]  key_rdata, val_rdata;
	logic [LINK_W-1:0]  link_ram_q, link_rd, link_wdata;
	logic               link_we;
	logic [ADDR_W-1:0]  link_waddr;
	logic               out_free;

	// Stores
	almm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk(clk), .we(ctl.add_wr), .waddr(free_head_q[ADDR_W-1:0]), .wdata(key_q),
		.re(re), .raddr(raddr), .rdata(key_rdata)
	);
	almm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
		.clk(clk), .we(ctl.add_wr), .waddr(free_head_q[ADDR_W-1:0]), .wdata(val_q),
		.re(re), .raddr(raddr), .rdata(val_rdata)
	);
	almm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(re), .raddr(raddr), .rdata(link_ram_q)
	);

	// Never-written link entries read as their reset free-chain successor
	assign link_rd = link_ok_q[rd_addr_q] ? link_ram_q
		: LINK_W'(rd_addr_q) + LINK_W'(1);

	// Read address: free head for add, list head to start a walk, next link while walking
	always_comb begin
		re    = ctl.rd_free | ctl.rd_head | ctl.walk_adv;
		raddr = link_rd[ADDR_W-1:0];
		if (ctl.rd_free) begin
			raddr = free_head_q[ADDR_W-1:0];
		end else if (ctl.rd_head) begin
			raddr = list_head_q[ADDR_W-1:0];
		end
	end

	// Link store writes: add links new slot to old head, remove splices then frees
	always_comb begin
		link_we    = 1'b0;
		link_waddr = free_head_q[ADDR_W-1:0];
		link_wdata = list_head_q;
		if (ctl.add_wr) begin
			link_we = 1'b1;
		end else if (ctl.unlink_a && (prev_q < NIL)) begin
			link_we    = 1'b1;
			link_waddr = prev_q[ADDR_W-1:0];
			link_wdata = link_rd;
		end else if (ctl.unlink_b) begin
			link_we    = 1'b1;
			link_waddr = cur_q[ADDR_W-1:0];
			link_wdata = free_head_q;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Status to controller
	always_comb begin
		stat.cmd        = cmd_q;
		stat.full       = (count_q >= CNT_W'(CAPACITY)) || (free_head_q >= NIL);
		stat.list_nil   = (list_head_q >= NIL);
		stat.cnt_zero   = (count_q == '0);
		stat.key_hit    = (key_rdata == key_q);
		stat.pair_hit   = (key_rdata == key_q) && (val_rdata == val_q);
		stat.walk_end   = (link_rd >= NIL) || (steps_q == ADDR_W'(CAPACITY - 1));
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q  <= NIL;
			free_head_q  <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			link_ok_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.add_wr) begin
				list_head_q <= free_head_q;
				free_head_q <= link_rd;
				count_q     <= count_q + CNT_W'(1);
			end
			if (ctl.unlink_a && (prev_q >= NIL)) begin
				list_head_q <= link_rd;
			end
			if (ctl.unlink_b) begin
				free_head_q <= cur_q;
				if (count_q != '0) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (link_we) begin
				link_ok_q[link_waddr] <= 1'b1;
			end
			if (ctl.rd_head) begin
				pend_valid_q <= 1'b0;
			end else if (ctl.walk_adv && (cmd_q == CMD_SEARCH) && stat.key_hit) begin
				pend_valid_q <= 1'b1;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(in_cmd);
			key_q <= in_key;
			val_q <= in_value;
		end
		if (re) begin
			rd_addr_q <= raddr;
		end
		if (ctl.rd_free) begin
			cur_q <= free_head_q;
		end else if (ctl.rd_head) begin
			cur_q   <= list_head_q;
			prev_q  <= NIL;
			steps_q <= '0;
		end else if (ctl.walk_adv) begin
			cur_q   <= link_rd;
			prev_q  <= cur_q;
			steps_q <= steps_q + ADDR_W'(1);
		end
		if (ctl.walk_adv && (cmd_q == CMD_SEARCH) && stat.key_hit) begin
			pend_q <= val_rdata;
		end
		if (ctl.walk_adv && (cmd_q == CMD_MIN)
				&& ((steps_q == '0) || ($signed(key_rdata) < $signed(best_q)))) begin
			best_q <= key_rdata;
		end
		if (ctl.emit) begin
			out_status   <= ctl.emit_status;
			out_found    <= (ctl.emit_src == SRC_PEND) ? pend_q : '0;
			out_smallest <= (ctl.emit_src == SRC_BEST) ? best_q : '0;
			out_last     <= ctl.emit_last;
			out_count    <= count_q;
			out_empty    <= (count_q == '0);
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// A result is only loaded when the output register is free or draining
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	// Free chain is exhausted exactly when the table is full
	a_free_full: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == NIL) == (count_q == CNT_W'(CAPACITY)))
		else $error("free chain and entry count disagree");

	// An add grows the entry count by one
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add_wr |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("add did not bump entry count");

	// The link store is never written while a walk step reads it
	a_walk_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_adv |-> !link_we)
		else $error("link write during walk step");
`endif

endmodule

// ----- hdl/almm_ctrl.sv -----
// Controller: command sequencing state machine for add, remove, search and minimum.
module almm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  almm_pkg::dp_stat_t stat,
	output almm_pkg::dp_ctrl_t ctl
);
	import almm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ADD_WR,
		S_WALK,
		S_UNLINK,
		S_RESULT
	} state_t;

	state_t  state_q;
	status_t res_status_q;
	src_t    res_src_q;
	logic    search_stall;
	logic    found_any;

	// Search must flush a held match before taking the next one
	assign search_stall = stat.key_hit && stat.pend_valid && !stat.out_free;
	assign found_any    = stat.pend_valid || stat.key_hit;
	assign in_ready     = (state_q == S_IDLE);

	// Command decode
	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				ctl.load = in_valid;
			end
			S_START: begin
				case (stat.cmd)
					CMD_ADD:    ctl.rd_free = !stat.full;
					CMD_MIN:    ctl.rd_head = !(stat.cnt_zero || stat.list_nil);
					default:    ctl.rd_head = !stat.list_nil;
				endcase
			end
			S_ADD_WR: begin
				ctl.add_wr = 1'b1;
			end
			S_WALK: begin
				case (stat.cmd)
					CMD_REMOVE: begin
						ctl.unlink_a = stat.pair_hit;
						ctl.walk_adv = !stat.pair_hit;
					end
					CMD_SEARCH: begin
						ctl.walk_adv = !search_stall;
						if (stat.key_hit && stat.pend_valid && stat.out_free) begin
							ctl.emit        = 1'b1;
							ctl.emit_src    = SRC_PEND;
							ctl.emit_status = ST_OK;
						end
					end
					CMD_MIN:    ctl.walk_adv = 1'b1;
					default:    ctl.walk_adv = 1'b0;
				endcase
			end
			S_UNLINK: begin
				ctl.unlink_b = 1'b1;
			end
			S_RESULT: begin
				ctl.emit        = stat.out_free;
				ctl.emit_src    = res_src_q;
				ctl.emit_status = res_status_q;
				ctl.emit_last   = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// State and result selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
			res_src_q    <= SRC_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					res_src_q    <= SRC_NONE;
					res_status_q <= ST_MISS;
					case (stat.cmd)
						CMD_ADD: begin
							res_status_q <= ST_FULL;
							state_q      <= stat.full ? S_RESULT : S_ADD_WR;
						end
						CMD_MIN: begin
							state_q <= (stat.cnt_zero || stat.list_nil) ? S_RESULT : S_WALK;
						end
						default: begin
							state_q <= stat.list_nil ? S_RESULT : S_WALK;
						end
					endcase
				end
				S_ADD_WR: begin
					res_status_q <= ST_OK;
					res_src_q    <= SRC_NONE;
					state_q      <= S_RESULT;
				end
				S_WALK: begin
					case (stat.cmd)
						CMD_REMOVE: begin
							if (stat.pair_hit) begin
								state_q <= S_UNLINK;
							end else if (stat.walk_end) begin
								res_status_q <= ST_MISS;
								res_src_q    <= SRC_NONE;
								state_q      <= S_RESULT;
							end
						end
						CMD_SEARCH: begin
							if (!search_stall && stat.walk_end) begin
								res_status_q <= found_any ? ST_OK : ST_MISS;
								res_src_q    <= found_any ? SRC_PEND : SRC_NONE;
								state_q      <= S_RESULT;
							end
						end
						CMD_MIN: begin
							if (stat.walk_end) begin
								res_status_q <= ST_OK;
								res_src_q    <= SRC_BEST;
								state_q      <= S_RESULT;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_UNLINK: begin
					res_status_q <= ST_OK;
					res_src_q    <= SRC_NONE;
					state_q      <= S_RESULT;
				end
				S_RESULT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/array_linked_multimap_engine.sv -----
// Multimap engine top level: one command in, one or more results out.
// Pairs live in a singly linked list over 64-slot key, value and link stores, with unused
// slots on a free chain. An add steps through the start, write and result states; search,
// minimum and a remove that misses step through start, one walk step per list entry
// visited, then result; a remove that finds its pair adds an unlink step to splice and
// free the slot. Each walk step is one read of the link store feeding the next address.
// A new command is taken only once the previous one has produced its last result; a
// finished result waits in the output register without holding off the next command.
// Search gives one result per match, newest first, and stalls its walk while the output
// is not taken. Adding to a full table is refused with the full status.
module array_linked_multimap_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] key,
	input  logic signed [31:0] item_value,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         status,
	output logic signed [31:0] found_value,
	output logic signed [31:0] smallest_key,
	output logic               last,
	output logic [6:0]         entry_count,
	output logic               empty_res
);
	import almm_pkg::*;

	dp_ctrl_t   ctl;
	dp_stat_t   stat;
	logic [31:0] found_raw, smallest_raw;

	// Sequencer
	almm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_valid),
		.in_ready (cmd_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Stores and result register
	almm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.in_cmd       (cmd),
		.in_key       (key),
		.in_value     (item_value),
		.out_valid    (res_valid),
		.out_ready    (res_ready),
		.out_status   (status),
		.out_found    (found_raw),
		.out_smallest (smallest_raw),
		.out_last     (last),
		.out_count    (entry_count),
		.out_empty    (empty_res)
	);

	assign found_value  = $signed(found_raw);
	assign smallest_key = $signed(smallest_raw);

endmodule

// ----- tb/array_linked_multimap_engine_test.sv -----
// Self-checking testbench for the linked-list multimap engine with a built-in list predictor.
`timescale 1ns / 1ps

module array_linked_multimap_engine_test;
	import almm_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_AFTER   = 150;   // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_LIMIT   = 3000;  // cycles without any transfer

	typedef struct {
		cmd_t               op;
		logic signed [31:0] k;
		logic signed [31:0] v;
	} cmd_item_t;

	typedef struct {
		status_t            st;
		logic signed [31:0] fval;
		logic signed [31:0] mkey;
		logic               fin;
		logic [CNT_W-1:0]   cnt;
		logic               emp;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	logic [1:0]         cmd = '0;
	logic signed [31:0] key = '0;
	logic signed [31:0] item_value = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] found_value;
	logic signed [31:0] smallest_key;
	logic               last;
	logic [6:0]         entry_count;
	logic               empty_res;

	array_linked_multimap_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.key          (key),
		.item_value   (item_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.found_value  (found_value),
		.smallest_key (smallest_key),
		.last         (last),
		.entry_count  (entry_count),
		.empty_res    (empty_res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Commands waiting to be driven, and replies the list predicts
	cmd_item_t cmd_q[$];
	reply_t    reply_q[$];

	// Predicted list state
	logic signed [31:0] key_mem   [CAPACITY];
	logic signed [31:0] value_mem [CAPACITY];
	logic [LINK_W-1:0]  link_mem  [CAPACITY];
	logic [LINK_W-1:0]  head_ptr;
	logic [LINK_W-1:0]  free_ptr;
	logic [CNT_W-1:0]   pairs_held;

	// Stimulus-side shadow of the stored pairs, newest first
	logic signed [31:0] shadow_k[$];
	logic signed [31:0] shadow_v[$];

	int total_items;
	int sent_cnt;
	int results_seen;
	int mismatches;
	int unexpected;
	int n_add_ok, n_refused, n_rm_hit, n_rm_miss, n_search_hits, n_search_miss, n_min;

	task automatic push_reply(input status_t st, input logic signed [31:0] fv,
			input logic signed [31:0] mk, input logic fin);
		reply_t r;
		r.st   = st;
		r.fval = fv;
		r.mkey = mk;
		r.fin  = fin;
		r.cnt  = pairs_held;
		r.emp  = (pairs_held == 0);
		reply_q.insert(reply_q.size(), r);
	endtask

	// Apply one command to the predicted list and queue the replies it causes
	task automatic apply_command(input cmd_t op, input logic signed [31:0] k,
			input logic signed [31:0] v);
		logic [LINK_W-1:0]  cur;
		logic [LINK_W-1:0]  prev;
		logic               hit;
		logic signed [31:0] held_val;
		logic signed [31:0] best;
		int                 steps;
		int                 hits;
		case (op)
			CMD_ADD: begin
				if (pairs_held >= CAPACITY || free_ptr >= NIL) begin
					push_reply(ST_FULL, '0, '0, 1'b1);
					n_refused++;
				end else begin
					cur = free_ptr;
					free_ptr = link_mem[cur];
					key_mem[cur] = k;
					value_mem[cur] = v;
					link_mem[cur] = head_ptr;
					head_ptr = cur;
					pairs_held++;
					push_reply(ST_OK, '0, '0, 1'b1);
					n_add_ok++;
				end
			end
			CMD_REMOVE: begin
				cur = head_ptr;
				prev = NIL;
				hit = 1'b0;
				steps = 0;
				while (!hit && steps < CAPACITY && cur < NIL) begin
					if (key_mem[cur] == k && value_mem[cur] == v) begin
						hit = 1'b1;
					end else begin
						prev = cur;
						cur = link_mem[cur];
						steps++;
					end
				end
				if (hit) begin
					if (prev >= NIL)
						head_ptr = link_mem[cur];
					else
						link_mem[prev] = link_mem[cur];
					link_mem[cur] = free_ptr;
					free_ptr = cur;
					if (pairs_held > 0)
						pairs_held--;
					push_reply(ST_OK, '0, '0, 1'b1);
					n_rm_hit++;
				end else begin
					push_reply(ST_MISS, '0, '0, 1'b1);
					n_rm_miss++;
				end
			end
			CMD_SEARCH: begin
				// a match is queued once the next one is known, so only the final one is marked
				cur = head_ptr;
				hits = 0;
				held_val = '0;
				for (steps = 0; steps < CAPACITY && cur < NIL; steps++) begin
					if (key_mem[cur] == k) begin
						if (hits > 0)
							push_reply(ST_OK, held_val, '0, 1'b0);
						held_val = value_mem[cur];
						hits++;
					end
					cur = link_mem[cur];
				end
				if (hits == 0) begin
					push_reply(ST_MISS, '0, '0, 1'b1);
					n_search_miss++;
				end else begin
					push_reply(ST_OK, held_val, '0, 1'b1);
					n_search_hits += hits;
				end
			end
			default: begin
				n_min++;
				if (pairs_held == 0 || head_ptr >= NIL) begin
					push_reply(ST_MISS, '0, '0, 1'b1);
				end else begin
					best = key_mem[head_ptr];
					cur = head_ptr;
					for (steps = 0; steps < CAPACITY && cur < NIL; steps++) begin
						if (key_mem[cur] < best)
							best = key_mem[cur];
						cur = link_mem[cur];
					end
					push_reply(ST_OK, '0, best, 1'b1);
				end
			end
		endcase
	endtask

	// Queue a command and track what the table will hold after it
	task automatic queue_cmd(input cmd_t op, input logic signed [31:0] k,
			input logic signed [31:0] v);
		cmd_item_t it;
		int        idx;
		it.op = op;
		it.k  = k;
		it.v  = v;
		cmd_q.insert(cmd_q.size(), it);
		if (op == CMD_ADD && shadow_k.size() < CAPACITY) begin
			shadow_k.push_front(k);
			shadow_v.push_front(v);
		end else if (op == CMD_REMOVE) begin
			idx = -1;
			for (int i = 0; i < shadow_k.size() && idx < 0; i++)
				if (shadow_k[i] == k && shadow_v[i] == v)
					idx = i;
			if (idx >= 0) begin
				shadow_k.delete(idx);
				shadow_v.delete(idx);
			end
		end
	endtask

	// Keys mostly from a small pool so searches hit several entries
	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return -32'sd2;
			5: return 32'sd5;
			6: return 32'sd100;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 7);
		return $urandom;
	endfunction

	// Command driver: bursts with random gaps, payload held until transfer
	int        burst_left = 1;
	int        gap_left = 0;
	cmd_item_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid  <= 1'b0;
			cmd        <= '0;
			key        <= '0;
			item_value <= '0;
			sent_cnt   <= 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				apply_command(cmd_t'(cmd), key, item_value);
				sent_cnt <= sent_cnt + 1;
			end
			if (cmd_valid && !cmd_ready) begin
				// hold the offered command
			end else if (gap_left > 0) begin
				gap_left  <= gap_left - 1;
				cmd_valid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				drv_item   = cmd_q.pop_front();
				cmd        <= drv_item.op;
				key        <= drv_item.k;
				item_value <= drv_item.v;
				cmd_valid  <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall mask re-chosen after each pass through its bits, one long hold-off
	logic [15:0] stall_mask = 16'hFFFF;
	int          mask_pos = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			mask_pos  <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else begin
			res_ready <= stall_mask[mask_pos];
			if (mask_pos == 15) begin
				mask_pos   <= 0;
				stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
					: (16'($urandom) | 16'($urandom_range(0, 65535)));
			end else begin
				mask_pos <= mask_pos + 1;
			end
		end
	end

	// Result monitor: compare each transfer with the oldest predicted reply
	reply_t want;

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			results_seen <= results_seen + 1;
			if (reply_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("[%0t] result with none expected: status=%0d value=%0d",
						$realtime, status, found_value);
			end else begin
				want = reply_q.pop_front();
				if (status != want.st || found_value != want.fval || smallest_key != want.mkey
						|| last != want.fin || entry_count != want.cnt
						|| empty_res != want.emp) begin
					mismatches++;
					if (mismatches + unexpected <= 10) begin
						$display("[%0t] mismatch: exp st=%0d val=%0d min=%0d last=%0b cnt=%0d emp=%0b",
							$realtime, want.st, want.fval, want.mkey, want.fin, want.cnt,
							want.emp);
						$display("    got st=%0d val=%0d min=%0d last=%0b cnt=%0d emp=%0b",
							status, found_value, smallest_key, last, entry_count, empty_res);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin : main
		int                 roll;
		int                 idx;
		int                 full_left;
		int                 low_mark;
		logic               grow;
		logic signed [31:0] k;
		logic signed [31:0] v;

		results_seen = 0;
		mismatches = 0;
		unexpected = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			key_mem[i]   = '0;
			value_mem[i] = '0;
			link_mem[i]  = LINK_W'(i + 1);
		end
		head_ptr   = NIL;
		free_ptr   = '0;
		pairs_held = '0;

		// Directed: empty table, extreme keys and values, duplicates, partial matches
		queue_cmd(CMD_MIN,    32'sd0, 32'sd0);
		queue_cmd(CMD_REMOVE, 32'sd0, 32'sd0);
		queue_cmd(CMD_SEARCH, 32'sd0, 32'sd0);
		queue_cmd(CMD_ADD,    32'sh8000_0000, 32'sh7FFF_FFFF);
		queue_cmd(CMD_ADD,    32'sh7FFF_FFFF, 32'sh8000_0000);
		queue_cmd(CMD_ADD,    32'sd0, 32'sd0);
		queue_cmd(CMD_ADD,    32'sh7FFF_FFFF, -32'sd1);
		queue_cmd(CMD_ADD,    32'sh8000_0000, 32'sh7FFF_FFFF);
		queue_cmd(CMD_SEARCH, 32'sh7FFF_FFFF, 32'sd0);
		queue_cmd(CMD_SEARCH, 32'sh8000_0000, 32'sd0);
		queue_cmd(CMD_SEARCH, 32'sd12345, 32'sd0);
		queue_cmd(CMD_MIN,    -32'sd1, -32'sd1);
		queue_cmd(CMD_REMOVE, 32'sh7FFF_FFFF, 32'sd0);
		queue_cmd(CMD_REMOVE, 32'sh8000_0000, 32'sh7FFF_FFFF);
		queue_cmd(CMD_SEARCH, 32'sh8000_0000, 32'sd0);
		queue_cmd(CMD_REMOVE, 32'sd0, 32'sd0);
		queue_cmd(CMD_REMOVE, 32'sh8000_0000, 32'sh7FFF_FFFF);
		queue_cmd(CMD_MIN,    32'sd0, 32'sd0);
		queue_cmd(CMD_REMOVE, 32'sh7FFF_FFFF, 32'sh8000_0000);
		queue_cmd(CMD_REMOVE, 32'sh7FFF_FFFF, -32'sd1);
		queue_cmd(CMD_MIN,    32'sd0, 32'sd0);
		queue_cmd(CMD_ADD,    -32'sd1, -32'sd2);
		queue_cmd(CMD_ADD,    -32'sd2, -32'sd1);
		queue_cmd(CMD_MIN,    32'sd0, 32'sd0);

		// Random: fill to full, push against the full table, drain, repeat
		grow = 1'b1;
		full_left = 0;
		low_mark = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			if (grow && shadow_k.size() == CAPACITY) begin
				grow = 1'b0;
				full_left = 12;
			end else if (!grow && full_left == 0 && shadow_k.size() <= low_mark) begin
				grow = 1'b1;
				low_mark = $urandom_range(0, 6);
			end
			k = pick_key();
			v = pick_value();
			if (shadow_k.size() > 0)
				idx = $urandom_range(0, shadow_k.size() - 1);
			else
				idx = -1;
			if (full_left > 0) begin
				full_left--;
				if (roll < 50)
					queue_cmd(CMD_ADD, k, v);
				else if (roll < 85)
					queue_cmd(CMD_SEARCH, (idx >= 0) ? shadow_k[idx] : k, v);
				else
					queue_cmd(CMD_MIN, k, v);
			end else if (grow ? roll < 65 : roll < 10) begin
				// occasionally repeat a stored pair
				if (idx >= 0 && $urandom_range(0, 6) == 0)
					queue_cmd(CMD_ADD, shadow_k[idx], shadow_v[idx]);
				else
					queue_cmd(CMD_ADD, k, v);
			end else if (grow ? roll < 75 : roll < 55) begin
				if (idx >= 0)
					queue_cmd(CMD_REMOVE, shadow_k[idx], shadow_v[idx]);
				else
					queue_cmd(CMD_REMOVE, k, v);
			end else if (grow ? roll < 80 : roll < 65) begin
				// key present, value probably not
				queue_cmd(CMD_REMOVE, (idx >= 0) ? shadow_k[idx] : k, v);
			end else if (roll < 90) begin
				queue_cmd(CMD_SEARCH, (idx >= 0 && roll < 87) ? shadow_k[idx] : k, v);
			end else begin
				queue_cmd(CMD_MIN, k, v);
			end
		end
		total_items = cmd_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt < total_items || reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands, checked %0d results: %0d adds, %0d refused as full,",
			total_items, results_seen, n_add_ok, n_refused);
		$display("%0d removes hit, %0d missed, %0d search matches, %0d searches empty, %0d minimum",
			n_rm_hit, n_rm_miss, n_search_hits, n_search_miss, n_min);
		if (mismatches == 0 && unexpected == 0 && reply_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
				reply_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
